// File: sv/wspi_pkg.sv
// Shared widths, types and constants of the wheel speed PI controller.
package wspi_pkg;

   localparam int COUNT_W  = 16;                 // encoder count fields
   localparam int SAMPLE_W = 18;                 // right + left - target
   localparam int ERR_W    = 26;                 // filtered error, Q.8
   localparam int DIFF_W   = 27;                 // sample - filtered error
   localparam int INTEG_W  = 26;                 // error integral, Q.8
   localparam int PREV_W   = 24;                 // previous drive, Q.8
   localparam int ACC_W    = 46;                 // multiply-accumulate width
   localparam int QACC_W   = ACC_W - 8;          // accumulator after floor shift
   localparam int MPLR_W   = 16;                 // multiplier operand width
   localparam int DIGIT_W  = 4;                  // radix-4 digit counter
   localparam int WGT_W    = 9;                  // Q1.8 weights
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Radix-4 digits needed per multiplier kind
   localparam logic [DIGIT_W-1:0] WGT_DIGITS  = 4'd5;
   localparam logic [DIGIT_W-1:0] GAIN_DIGITS = 4'd8;

   localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT  = 3'd6;

   // CSR reset values
   localparam logic [15:0]        RST_TARGET_COUNT = 16'd350;
   localparam logic signed [15:0] RST_PROP_GAIN    = -16'sd15360;
   localparam logic signed [15:0] RST_INTEG_GAIN   = -16'sd77;
   localparam logic [WGT_W-1:0]   RST_ERROR_WEIGHT = 9'd51;
   localparam logic [WGT_W-1:0]   RST_BLEND_WEIGHT = 9'd26;
   localparam logic [15:0]        RST_INTEG_LIMIT  = 16'd10000;
   localparam logic [14:0]        RST_DRIVE_LIMIT  = 15'd8000;

   typedef struct packed {
      logic [15:0]        target_count;
      logic signed [15:0] prop_gain;
      logic signed [15:0] integ_gain;
      logic [WGT_W-1:0]   error_weight;
      logic [WGT_W-1:0]   blend_weight;
      logic [15:0]        integ_limit;
      logic [14:0]        drive_limit;
   } cfg_type;

   typedef struct packed {
      logic                     start;
      logic                     clear;
      logic signed [ACC_W-1:0]  mcand;
      logic signed [MPLR_W-1:0] mplier;
      logic [DIGIT_W-1:0]       digits;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mac_sts_type;

   // weights above one act as one
   function automatic logic [WGT_W-1:0] eff_weight(input logic [WGT_W-1:0] w);
      eff_weight = (w > WGT_ONE) ? WGT_ONE : w;
   endfunction

endpackage

// File: sv/wspi_booth_mac.sv
// Radix-4 Booth serial multiply-accumulate unit, two multiplier bits per cycle.
module wspi_booth_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  wspi_pkg::mac_ctl_type             ctl,
   output wspi_pkg::mac_sts_type             sts,
   output logic signed [wspi_pkg::ACC_W-1:0] acc
);
   import wspi_pkg::*;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  mcand_ff, mcand_in;
   logic [MPLR_W:0]          mplier_ff, mplier_in;
   logic [DIGIT_W-1:0]       cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic signed [ACC_W-1:0]  addend;

   always_comb begin
      unique case (mplier_ff[2:0])
         3'b001, 3'b010: addend = mcand_ff;
         3'b011:         addend = mcand_ff <<< 1;
         3'b100:         addend = -(mcand_ff <<< 1);
         3'b101, 3'b110: addend = -mcand_ff;
         default:        addend = '0;
      endcase
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.start) begin
         acc_in    = ctl.clear ? '0 : acc_ff;
         mcand_in  = ctl.mcand;
         mplier_in = {ctl.mplier, 1'b0};
         cnt_in    = ctl.digits;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + addend;
         mcand_in  = mcand_ff <<< 2;
         mplier_in = {{2{mplier_ff[MPLR_W]}}, mplier_ff[MPLR_W:2]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == DIGIT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign acc      = acc_ff;

endmodule

// File: sv/wspi_seq.sv
// Control tick sequencer: filter, integral clamp, gains, blend and saturation.
module wspi_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  wspi_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [wspi_pkg::COUNT_W-1:0] right_count,
   input  logic signed [wspi_pkg::COUNT_W-1:0] left_count,
   input  logic                                slot_free,
   output logic                                res_valid,
   output logic signed [15:0]                  res_drive,
   output logic                                res_saturated
);
   import wspi_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE       = 10'b0000000001,
      S_ERR        = 10'b0000000010,
      S_ERR_WAIT   = 10'b0000000100,
      S_INTEG      = 10'b0000001000,
      S_PG_WAIT    = 10'b0000010000,
      S_IG         = 10'b0000100000,
      S_IG_WAIT    = 10'b0001000000,
      S_BLEND      = 10'b0010000000,
      S_BLEND_WAIT = 10'b0100000000,
      S_DONE       = 10'b1000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [ERR_W-1:0]    fe_ff, fe_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [PREV_W-1:0]   prev_ff, prev_in;
   logic signed [QACC_W-1:0]   blend_ff, blend_in;

   mac_ctl_type               mac_ctl;
   mac_sts_type               mac_sts;
   logic signed [ACC_W-1:0]   mac_acc;
   logic signed [QACC_W-1:0]  acc_q;

   logic signed [DIFF_W-1:0]  err_diff;
   logic signed [INTEG_W:0]   isum, ilim, integ_next;
   logic signed [QACC_W-1:0]  raw_diff, dlim, sat_val;
   logic                      sat_hit;

   wspi_booth_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .sts   (mac_sts),
      .acc   (mac_acc)
   );

   // floor shift by 8
   assign acc_q = mac_acc[ACC_W-1:8];

   assign err_diff = {sample_ff[SAMPLE_W-1], sample_ff, 8'h00}
                   - {fe_ff[ERR_W-1], fe_ff};

   assign isum = {fe_ff[ERR_W-1], fe_ff} + {integ_ff[INTEG_W-1], integ_ff};
   assign ilim = {3'b000, cfg.integ_limit, 8'h00};

   always_comb begin
      priority if (isum > ilim)  integ_next = ilim;
      else if (isum < -ilim)     integ_next = -ilim;
      else                       integ_next = isum;
   end

   assign raw_diff = acc_q - {{(QACC_W-PREV_W){prev_ff[PREV_W-1]}}, prev_ff};
   assign dlim     = {{(QACC_W-23){1'b0}}, cfg.drive_limit, 8'h00};

   always_comb begin
      sat_hit = 1'b1;
      priority if (blend_ff > dlim) sat_val = dlim;
      else if (blend_ff < -dlim)    sat_val = -dlim;
      else begin
         sat_val = blend_ff;
         sat_hit = 1'b0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      fe_in     = fe_ff;
      integ_in  = integ_ff;
      prev_in   = prev_ff;
      blend_in  = blend_ff;
      mac_ctl   = '0;
      in_ready  = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               sample_in = {{2{right_count[COUNT_W-1]}}, right_count}
                         + {{2{left_count[COUNT_W-1]}}, left_count}
                         - {2'b00, cfg.target_count};
               state_in  = S_ERR;
            end
         end
         S_ERR: begin
            mac_ctl.start  = 1'b1;
            mac_ctl.clear  = 1'b1;
            mac_ctl.mcand  = {{(ACC_W-DIFF_W){err_diff[DIFF_W-1]}}, err_diff};
            mac_ctl.mplier = {{(MPLR_W-WGT_W){1'b0}}, eff_weight(cfg.error_weight)};
            mac_ctl.digits = WGT_DIGITS;
            state_in       = S_ERR_WAIT;
         end
         S_ERR_WAIT: begin
            if (mac_sts.done) begin
               fe_in    = fe_ff + acc_q[ERR_W-1:0];
               state_in = S_INTEG;
            end
         end
         S_INTEG: begin
            integ_in       = integ_next[INTEG_W-1:0];
            mac_ctl.start  = 1'b1;
            mac_ctl.clear  = 1'b1;
            mac_ctl.mcand  = {{(ACC_W-ERR_W){fe_ff[ERR_W-1]}}, fe_ff};
            mac_ctl.mplier = cfg.prop_gain;
            mac_ctl.digits = GAIN_DIGITS;
            state_in       = S_PG_WAIT;
         end
         S_PG_WAIT: begin
            if (mac_sts.done) state_in = S_IG;
         end
         S_IG: begin
            mac_ctl.start  = 1'b1;
            mac_ctl.clear  = 1'b0;
            mac_ctl.mcand  = {{(ACC_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff};
            mac_ctl.mplier = cfg.integ_gain;
            mac_ctl.digits = GAIN_DIGITS;
            state_in       = S_IG_WAIT;
         end
         S_IG_WAIT: begin
            if (mac_sts.done) state_in = S_BLEND;
         end
         S_BLEND: begin
            mac_ctl.start  = 1'b1;
            mac_ctl.clear  = 1'b1;
            mac_ctl.mcand  = {{(ACC_W-QACC_W){raw_diff[QACC_W-1]}}, raw_diff};
            mac_ctl.mplier = {{(MPLR_W-WGT_W){1'b0}}, eff_weight(cfg.blend_weight)};
            mac_ctl.digits = WGT_DIGITS;
            state_in       = S_BLEND_WAIT;
         end
         S_BLEND_WAIT: begin
            if (mac_sts.done) begin
               blend_in = {{(QACC_W-PREV_W){prev_ff[PREV_W-1]}}, prev_ff} + acc_q;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               res_valid = 1'b1;
               prev_in   = sat_val[PREV_W-1:0];
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res_drive     = sat_val[PREV_W-1:8];
   assign res_saturated = sat_hit;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      blend_ff  <= blend_in;
      if (reset) begin
         state_ff <= S_IDLE;
         fe_ff    <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fe_ff    <= fe_in;
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

// File: sv/wheel_speed_pi_controller_core.sv
// Top level of the wheel speed PI controller: CSRs, request and response channels.
//
// One request carries the right and left encoder counts of a control tick and
// yields one response with the smoothed, saturated drive and a clip flag. The
// error filter, the two gain products and the output blend all run on a single
// radix-4 Booth serial multiply-accumulate unit, one product at a time, each
// with a setup and a completion state: two by a Q1.8 weight, two by a Q8.8
// gain. A final state does saturation and handoff. A finished response sits
// in an output register, so the next request is taken while it waits, in the
// cycle in which the response first shows as valid; none is taken before the
// last has left the sequencer. CSRs must be written only while no request is
// in flight; the block itself does not enforce this.
module wheel_speed_pi_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,   // right_count, left_count
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,   // drive
   output logic                                 rsp_tuser,   // saturated
   input  logic                                 csr_wen,
   input  logic [wspi_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [wspi_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import wspi_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        drive_ff;
   logic               sat_ff;
   logic               slot_free;
   logic               res_valid;
   logic signed [15:0] res_drive;
   logic               res_saturated;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_TARGET_COUNT: cfg_in.target_count = csr_wdata;
            CSR_PROP_GAIN:    cfg_in.prop_gain    = csr_wdata;
            CSR_INTEG_GAIN:   cfg_in.integ_gain   = csr_wdata;
            CSR_ERROR_WEIGHT: cfg_in.error_weight = csr_wdata[WGT_W-1:0];
            CSR_BLEND_WEIGHT: cfg_in.blend_weight = csr_wdata[WGT_W-1:0];
            CSR_INTEG_LIMIT:  cfg_in.integ_limit  = csr_wdata;
            CSR_DRIVE_LIMIT:  cfg_in.drive_limit  = csr_wdata[14:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid)       rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   wspi_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .right_count   (req_tdata[15:0]),
      .left_count    (req_tdata[31:16]),
      .slot_free     (slot_free),
      .res_valid     (res_valid),
      .res_drive     (res_drive),
      .res_saturated (res_saturated)
   );

   always_ff @(posedge clock) begin
      if (res_valid) begin
         drive_ff <= res_drive;
         sat_ff   <= res_saturated;
      end
      if (reset) begin
         rsp_valid_ff        <= 1'b0;
         cfg_ff.target_count <= RST_TARGET_COUNT;
         cfg_ff.prop_gain    <= RST_PROP_GAIN;
         cfg_ff.integ_gain   <= RST_INTEG_GAIN;
         cfg_ff.error_weight <= RST_ERROR_WEIGHT;
         cfg_ff.blend_weight <= RST_BLEND_WEIGHT;
         cfg_ff.integ_limit  <= RST_INTEG_LIMIT;
         cfg_ff.drive_limit  <= RST_DRIVE_LIMIT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = sat_ff;

endmodule
